FILE: hdl/hpdt_pkg.sv
// Package for the HPACK header table: constants, command types and the static table ROM.
package hpdt_pkg;

  localparam int RING_BYTES     = 4096;
  localparam int STATIC_ENTRIES = 61;
  localparam int AW             = $clog2(RING_BYTES);
  localparam int ENTRY_OVERHEAD = 32;
  localparam int INITIAL_MAX    = 4096;
  localparam int DIV_W          = 18;
  localparam int ROM_CHARS      = 28;
  localparam int TXT_W          = ROM_CHARS * 8;

  localparam logic [2:0] REQ_SIZE      = 3'd0;
  localparam logic [2:0] REQ_INS_BEGIN = 3'd1;
  localparam logic [2:0] REQ_INS_BYTE  = 3'd2;
  localparam logic [2:0] REQ_LOOKUP    = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;

  localparam logic CFG_TABLE_LIMIT = 1'b0;
  localparam logic CFG_FIELD_CAP   = 1'b1;

  typedef struct packed {
    logic idle;
    logic latch;
    logic disp;
    logic shr_drop;
    logic hdr_step;
    logic hdr_next;
    logic mod_drop;
    logic mod_walk;
    logic ipos_start;
    logic ipos_set;
    logic ihdr_step;
    logic lk_chk;
  } cmd_t;

  typedef struct packed {
    logic disp_shrink;
    logic disp_walk;
    logic disp_lkchk;
    logic shr_need;
    logic shr_ins;
    logic hdr_done;
    logic hdr_final;
    logic mod_done;
    logic ihdr_done;
    logic is_lookup;
  } sts_t;

  typedef struct packed {
    logic [4:0]       nlen;
    logic [3:0]       vlen;
    logic [TXT_W-1:0] text;
  } rom_t;

  function automatic rom_t rom_entry(input logic [5:0] slot);
    rom_t r;
    r = '0;
    unique case (slot)
      6'd0:  r = '{5'd10, 4'd0,  TXT_W'(":authority")};
      6'd1:  r = '{5'd7,  4'd3,  TXT_W'(":methodGET")};
      6'd2:  r = '{5'd7,  4'd4,  TXT_W'(":methodPOST")};
      6'd3:  r = '{5'd5,  4'd1,  TXT_W'(":path/")};
      6'd4:  r = '{5'd5,  4'd11, TXT_W'(":path/index.html")};
      6'd5:  r = '{5'd7,  4'd4,  TXT_W'(":schemehttp")};
      6'd6:  r = '{5'd7,  4'd5,  TXT_W'(":schemehttps")};
      6'd7:  r = '{5'd7,  4'd3,  TXT_W'(":status200")};
      6'd8:  r = '{5'd7,  4'd3,  TXT_W'(":status204")};
      6'd9:  r = '{5'd7,  4'd3,  TXT_W'(":status206")};
      6'd10: r = '{5'd7,  4'd3,  TXT_W'(":status304")};
      6'd11: r = '{5'd7,  4'd3,  TXT_W'(":status400")};
      6'd12: r = '{5'd7,  4'd3,  TXT_W'(":status404")};
      6'd13: r = '{5'd7,  4'd3,  TXT_W'(":status500")};
      6'd14: r = '{5'd14, 4'd0,  TXT_W'("accept-charset")};
      6'd15: r = '{5'd15, 4'd13, TXT_W'("accept-encodinggzip, deflate")};
      6'd16: r = '{5'd15, 4'd0,  TXT_W'("accept-language")};
      6'd17: r = '{5'd13, 4'd0,  TXT_W'("accept-ranges")};
      6'd18: r = '{5'd6,  4'd0,  TXT_W'("accept")};
      6'd19: r = '{5'd27, 4'd0,  TXT_W'("access-control-allow-origin")};
      6'd20: r = '{5'd3,  4'd0,  TXT_W'("age")};
      6'd21: r = '{5'd5,  4'd0,  TXT_W'("allow")};
      6'd22: r = '{5'd13, 4'd0,  TXT_W'("authorization")};
      6'd23: r = '{5'd13, 4'd0,  TXT_W'("cache-control")};
      6'd24: r = '{5'd19, 4'd0,  TXT_W'("content-disposition")};
      6'd25: r = '{5'd16, 4'd0,  TXT_W'("content-encoding")};
      6'd26: r = '{5'd16, 4'd0,  TXT_W'("content-language")};
      6'd27: r = '{5'd14, 4'd0,  TXT_W'("content-length")};
      6'd28: r = '{5'd16, 4'd0,  TXT_W'("content-location")};
      6'd29: r = '{5'd13, 4'd0,  TXT_W'("content-range")};
      6'd30: r = '{5'd12, 4'd0,  TXT_W'("content-type")};
      6'd31: r = '{5'd6,  4'd0,  TXT_W'("cookie")};
      6'd32: r = '{5'd4,  4'd0,  TXT_W'("date")};
      6'd33: r = '{5'd4,  4'd0,  TXT_W'("etag")};
      6'd34: r = '{5'd6,  4'd0,  TXT_W'("expect")};
      6'd35: r = '{5'd7,  4'd0,  TXT_W'("expires")};
      6'd36: r = '{5'd4,  4'd0,  TXT_W'("from")};
      6'd37: r = '{5'd4,  4'd0,  TXT_W'("host")};
      6'd38: r = '{5'd8,  4'd0,  TXT_W'("if-match")};
      6'd39: r = '{5'd17, 4'd0,  TXT_W'("if-modified-since")};
      6'd40: r = '{5'd13, 4'd0,  TXT_W'("if-none-match")};
      6'd41: r = '{5'd8,  4'd0,  TXT_W'("if-range")};
      6'd42: r = '{5'd19, 4'd0,  TXT_W'("if-unmodified-since")};
      6'd43: r = '{5'd13, 4'd0,  TXT_W'("last-modified")};
      6'd44: r = '{5'd4,  4'd0,  TXT_W'("link")};
      6'd45: r = '{5'd8,  4'd0,  TXT_W'("location")};
      6'd46: r = '{5'd12, 4'd0,  TXT_W'("max-forwards")};
      6'd47: r = '{5'd18, 4'd0,  TXT_W'("proxy-authenticate")};
      6'd48: r = '{5'd19, 4'd0,  TXT_W'("proxy-authorization")};
      6'd49: r = '{5'd5,  4'd0,  TXT_W'("range")};
      6'd50: r = '{5'd7,  4'd0,  TXT_W'("referer")};
      6'd51: r = '{5'd7,  4'd0,  TXT_W'("refresh")};
      6'd52: r = '{5'd11, 4'd0,  TXT_W'("retry-after")};
      6'd53: r = '{5'd6,  4'd0,  TXT_W'("server")};
      6'd54: r = '{5'd10, 4'd0,  TXT_W'("set-cookie")};
      6'd55: r = '{5'd25, 4'd0,  TXT_W'("strict-transport-security")};
      6'd56: r = '{5'd17, 4'd0,  TXT_W'("transfer-encoding")};
      6'd57: r = '{5'd10, 4'd0,  TXT_W'("user-agent")};
      6'd58: r = '{5'd4,  4'd0,  TXT_W'("vary")};
      6'd59: r = '{5'd3,  4'd0,  TXT_W'("via")};
      6'd60: r = '{5'd16, 4'd0,  TXT_W'("www-authenticate")};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rom_byte(input logic [5:0] slot, input logic [4:0] k);
    rom_t       r;
    logic [5:0] tot;
    logic [5:0] sh;
    r   = rom_entry(slot);
    tot = 6'(r.nlen) + 6'(r.vlen);
    sh  = tot - 6'd1 - 6'(k);
    return r.text[sh[4:0]*8 +: 8];
  endfunction

endpackage

FILE: hdl/hpack_dynamic_table_ring.sv
// Top level of the HPACK header table with a byte-ring dynamic part.
// A request is taken when start is high and busy is low; its one result beat appears with
// done for exactly one cycle and cannot be held off. An insert byte, a read byte, a stray
// request, a failed size update or a rejected lookup index passes only the dispatch state
// before its result, and a static lookup adds the lookup check. A size update or insert begin
// evicts entries one by one, each with the 4-byte header read from the ring RAM and the
// remainder unit that wraps ring offsets; an insert begin that writes an entry then writes
// its header. A dynamic lookup walks from the oldest entry past every entry older than its target.
module hpack_dynamic_table_ring (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_name_length,
  input  logic [15:0] in_value_length,
  input  logic [15:0] in_table_index,
  input  logic        in_want_value,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_new_max_size,
  output logic        out_status,
  output logic [15:0] out_entry_name_length,
  output logic [15:0] out_entry_value_length,
  output logic [7:0]  out_read_data,
  output logic        out_last_octet,
  output logic [7:0]  out_entries_held,
  output logic [12:0] out_table_size
);

  hpdt_pkg::cmd_t cmd;
  hpdt_pkg::sts_t sts;

  hpdt_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  hpdt_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_req_type           (in_req_type),
    .in_name_length        (in_name_length),
    .in_value_length       (in_value_length),
    .in_table_index        (in_table_index),
    .in_want_value         (in_want_value),
    .in_data_byte          (in_data_byte),
    .in_new_max_size       (in_new_max_size),
    .out_status            (out_status),
    .out_entry_name_length (out_entry_name_length),
    .out_entry_value_length(out_entry_value_length),
    .out_read_data         (out_read_data),
    .out_last_octet        (out_last_octet),
    .out_entries_held      (out_entries_held),
    .out_table_size        (out_table_size)
  );

endmodule

FILE: hdl/hpdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hpdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/hpdt_mod.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
module hpdt_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hpdt_pkg::DIV_W-1:0] dividend,
  input  logic [12:0]               divisor,
  output logic                      done,
  output logic [12:0]               rem
);

  logic [hpdt_pkg::DIV_W-1:0] dvd_r, dvd_nxt;
  logic [13:0]                rem_r, rem_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic                       run_r, run_nxt;
  logic [13:0]                trial;

  assign trial = {rem_r[12:0], dvd_r[hpdt_pkg::DIV_W-1]};

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = (divisor != 13'd0);
    end else if (run_r) begin
      rem_nxt = (trial >= 14'(divisor)) ? trial - 14'(divisor) : trial;
      dvd_nxt = {dvd_r[hpdt_pkg::DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(hpdt_pkg::DIV_W - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      rem_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
  end

  assign done = !run_r;
  assign rem  = rem_r[12:0];

endmodule

FILE: hdl/hpdt_ctrl.sv
// Controller state machine that sequences requests, evictions and table walks.
module hpdt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  hpdt_pkg::sts_t sts,
  output hpdt_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_SHR   = 11'b00000000100,
    S_HDR   = 11'b00000001000,
    S_HNXT  = 11'b00000010000,
    S_MOD   = 11'b00000100000,
    S_IPOS  = 11'b00001000000,
    S_IMOD  = 11'b00010000000,
    S_IHDR  = 11'b00100000000,
    S_LKCHK = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.disp = 1'b1;
        priority if (sts.disp_shrink) state_nxt = S_SHR;
        else if (sts.disp_walk) state_nxt = S_HDR;
        else if (sts.disp_lkchk) state_nxt = S_LKCHK;
        else state_nxt = S_FIN;
      end
      S_SHR: begin
        priority if (sts.shr_need) begin
          cmd.shr_drop = 1'b1;
          state_nxt    = S_HDR;
        end else if (sts.shr_ins) begin
          state_nxt = S_IPOS;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_HDR: begin
        cmd.hdr_step = 1'b1;
        if (sts.hdr_done) state_nxt = S_HNXT;
      end
      S_HNXT: begin
        cmd.hdr_next = 1'b1;
        state_nxt    = sts.hdr_final ? S_LKCHK : S_MOD;
      end
      S_MOD: begin
        if (sts.mod_done) begin
          if (sts.is_lookup) begin
            cmd.mod_walk = 1'b1;
            state_nxt    = S_HDR;
          end else begin
            cmd.mod_drop = 1'b1;
            state_nxt    = S_SHR;
          end
        end
      end
      S_IPOS: begin
        cmd.ipos_start = 1'b1;
        state_nxt      = S_IMOD;
      end
      S_IMOD: begin
        if (sts.mod_done) begin
          cmd.ipos_set = 1'b1;
          state_nxt    = S_IHDR;
        end
      end
      S_IHDR: begin
        cmd.ihdr_step = 1'b1;
        if (sts.ihdr_done) state_nxt = S_FIN;
      end
      S_LKCHK: begin
        cmd.lk_chk = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_FIN);

  assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
    else $error("Result strobe lasted more than one cycle.");
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy && !done)
    else $error("Accepted request did not start work.");
  assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
    else $error("Result strobe while idle.");

endmodule

FILE: hdl/hpdt_dp.sv
// Datapath: table registers, ring memory, remainder unit, static ROM and result registers.
module hpdt_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  hpdt_pkg::cmd_t cmd,
  output hpdt_pkg::sts_t sts,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic [2:0]     in_req_type,
  input  logic [15:0]    in_name_length,
  input  logic [15:0]    in_value_length,
  input  logic [15:0]    in_table_index,
  input  logic           in_want_value,
  input  logic [7:0]     in_data_byte,
  input  logic [15:0]    in_new_max_size,
  output logic           out_status,
  output logic [15:0]    out_entry_name_length,
  output logic [15:0]    out_entry_value_length,
  output logic [7:0]     out_read_data,
  output logic           out_last_octet,
  output logic [7:0]     out_entries_held,
  output logic [12:0]    out_table_size
);

  localparam int AW = hpdt_pkg::AW;

  logic [12:0]   limit_r, limit_nxt, max_r, max_nxt;
  logic [15:0]   cap_r, cap_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt, wofs_r, wofs_nxt, rcur_r, rcur_nxt, pos_r, pos_nxt;
  logic [12:0]   bused_r, bused_nxt, acc_r, acc_nxt, target_r, target_nxt;
  logic [7:0]    count_r, count_nxt, skip_r, skip_nxt;
  logic [16:0]   wleft_r, wleft_nxt, wtot_r, wtot_nxt, rleft_r, rleft_nxt;
  logic          wbusy_r, wbusy_nxt, rbusy_r, rbusy_nxt, rrom_r, rrom_nxt;
  logic          fits_r, fits_nxt;
  logic [5:0]    slot_r, slot_nxt;
  logic [2:0]    step_r, step_nxt;

  logic [2:0]    req_r;
  logic [15:0]   nlen_r, vlen_r, idx_r, nmax_r;
  logic          want_r;
  logic [7:0]    db_r;
  logic [31:0]   hdr_r, hdr_nxt;
  logic [15:0]   lkn_r, lkn_nxt, lkv_r, lkv_nxt;
  logic          lkrom_r, lkrom_nxt;

  logic          ost_r, ost_nxt, olast_r, olast_nxt, ofram_r, ofram_nxt;
  logic [15:0]   onl_r, onl_nxt, ovl_r, ovl_nxt;
  logic [7:0]    ord_r, ord_nxt;

  logic [12:0]   ring_len;
  logic [16:0]   len;
  logic          too_big, lk_rom, lk_dyn_err;
  logic          mod_start, mod_done;
  logic [hpdt_pkg::DIV_W-1:0] mod_dvd;
  logic [12:0]   mod_rem;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [15:0]   hdr_n, hdr_v;
  logic [17:0]   drop_bytes, drop_acc;
  logic [16:0]   lk_nv;
  logic          lk_err;
  hpdt_pkg::rom_t rom_e;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p, input logic [12:0] l);
    logic [12:0] p1;
    p1 = 13'(p) + 13'd1;
    return (p1 >= l) ? '0 : p1[AW-1:0];
  endfunction

  assign ring_len = (limit_r > 13'(hpdt_pkg::RING_BYTES)) ? 13'(hpdt_pkg::RING_BYTES) : limit_r;
  assign len      = 17'(nlen_r) + 17'(vlen_r);
  assign too_big  = (18'(len) + 18'(hpdt_pkg::ENTRY_OVERHEAD)) > 18'(max_r);
  assign lk_rom   = (idx_r != 16'd0) && (idx_r <= 16'(hpdt_pkg::STATIC_ENTRIES));
  assign lk_dyn_err = idx_r >= (16'(count_r) + 16'(hpdt_pkg::STATIC_ENTRIES + 1));
  assign hdr_n    = hdr_r[31:16];
  assign hdr_v    = hdr_r[15:0];
  assign drop_bytes = 18'(hdr_n) + 18'(hdr_v) + 18'd4;
  assign drop_acc   = 18'(hdr_n) + 18'(hdr_v) + 18'(hpdt_pkg::ENTRY_OVERHEAD);
  assign lk_nv    = 17'(lkn_r) + 17'(lkv_r);
  assign lk_err   = (lkn_r > cap_r) || (want_r && (lk_nv > 17'(cap_r)));
  assign rom_e    = hpdt_pkg::rom_entry(idx_r[5:0] - 6'd1);

  assign sts.disp_shrink = ((req_r == hpdt_pkg::REQ_SIZE) && (nmax_r <= 16'(ring_len)))
                           || (req_r == hpdt_pkg::REQ_INS_BEGIN);
  assign sts.disp_walk   = (req_r == hpdt_pkg::REQ_LOOKUP) && (idx_r != 16'd0) && !lk_rom
                           && !lk_dyn_err;
  assign sts.disp_lkchk  = (req_r == hpdt_pkg::REQ_LOOKUP) && lk_rom;
  assign sts.shr_need    = (count_r != 8'd0) && (acc_r > target_r);
  assign sts.shr_ins     = (req_r == hpdt_pkg::REQ_INS_BEGIN) && fits_r;
  assign sts.hdr_done    = (step_r == 3'd4);
  assign sts.hdr_final   = (req_r == hpdt_pkg::REQ_LOOKUP) && (skip_r == 8'd0);
  assign sts.mod_done    = mod_done;
  assign sts.ihdr_done   = (step_r == 3'd3);
  assign sts.is_lookup   = (req_r == hpdt_pkg::REQ_LOOKUP);

  always_comb begin
    limit_nxt = limit_r;  cap_nxt = cap_r;        max_nxt = max_r;
    oldest_nxt = oldest_r; wofs_nxt = wofs_r;     rcur_nxt = rcur_r;   pos_nxt = pos_r;
    bused_nxt = bused_r;  acc_nxt = acc_r;        target_nxt = target_r;
    count_nxt = count_r;  skip_nxt = skip_r;
    wleft_nxt = wleft_r;  wtot_nxt = wtot_r;      rleft_nxt = rleft_r;
    wbusy_nxt = wbusy_r;  rbusy_nxt = rbusy_r;    rrom_nxt = rrom_r;   fits_nxt = fits_r;
    slot_nxt = slot_r;    step_nxt = step_r;      hdr_nxt = hdr_r;
    lkn_nxt = lkn_r;      lkv_nxt = lkv_r;        lkrom_nxt = lkrom_r;
    ost_nxt = ost_r;      olast_nxt = olast_r;    ofram_nxt = ofram_r;
    onl_nxt = onl_r;      ovl_nxt = ovl_r;        ord_nxt = ord_r;
    ram_we = 1'b0;        ram_waddr = pos_r;      ram_wdata = '0;
    ram_re = 1'b0;        ram_raddr = pos_r;
    mod_start = 1'b0;
    mod_dvd = hpdt_pkg::DIV_W'(pos_r) + hpdt_pkg::DIV_W'(hdr_n) + hpdt_pkg::DIV_W'(hdr_v);

    if (cmd.latch) begin
      ost_nxt = 1'b0; olast_nxt = 1'b0; ofram_nxt = 1'b0;
      onl_nxt = '0;   ovl_nxt = '0;     ord_nxt = '0;
    end

    if (cmd.disp) begin
      unique case (req_r)
        hpdt_pkg::REQ_SIZE: begin
          wbusy_nxt = 1'b0;
          rbusy_nxt = 1'b0;
          if (nmax_r > 16'(ring_len)) begin
            ost_nxt = 1'b1;
          end else begin
            max_nxt    = nmax_r[12:0];
            target_nxt = nmax_r[12:0];
          end
        end
        hpdt_pkg::REQ_INS_BEGIN: begin
          wbusy_nxt  = 1'b0;
          rbusy_nxt  = 1'b0;
          fits_nxt   = !too_big;
          target_nxt = too_big ? '0
                     : 13'(18'(max_r) - 18'(len) - 18'(hpdt_pkg::ENTRY_OVERHEAD));
        end
        hpdt_pkg::REQ_INS_BYTE: begin
          if (!wbusy_r) begin
            ost_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wofs_r;
            ram_wdata = db_r;
            wofs_nxt  = ring_inc(wofs_r, ring_len);
            wleft_nxt = wleft_r - 17'd1;
            if (wleft_r == 17'd1) begin
              bused_nxt = 13'(17'(bused_r) + wtot_r + 17'd4);
              acc_nxt   = 13'(17'(acc_r) + wtot_r + 17'(hpdt_pkg::ENTRY_OVERHEAD));
              count_nxt = count_r + 8'd1;
              wbusy_nxt = 1'b0;
            end
          end
        end
        hpdt_pkg::REQ_LOOKUP: begin
          rbusy_nxt = 1'b0;
          if (lk_rom) begin
            lkn_nxt   = 16'(rom_e.nlen);
            lkv_nxt   = 16'(rom_e.vlen);
            lkrom_nxt = 1'b1;
            slot_nxt  = idx_r[5:0] - 6'd1;
          end else if ((idx_r == 16'd0) || lk_dyn_err) begin
            ost_nxt = 1'b1;
          end else begin
            lkrom_nxt = 1'b0;
            pos_nxt   = oldest_r;
            step_nxt  = '0;
            skip_nxt  = 8'(16'(count_r) + 16'(hpdt_pkg::STATIC_ENTRIES) - idx_r);
          end
        end
        hpdt_pkg::REQ_READ: begin
          if (!rbusy_r) begin
            ost_nxt = 1'b1;
          end else begin
            if (rrom_r) begin
              ord_nxt  = hpdt_pkg::rom_byte(slot_r, rcur_r[4:0]);
              rcur_nxt = rcur_r + AW'(1);
            end else begin
              ram_re    = 1'b1;
              ram_raddr = rcur_r;
              ofram_nxt = 1'b1;
              rcur_nxt  = ring_inc(rcur_r, ring_len);
            end
            rleft_nxt = rleft_r - 17'd1;
            if (rleft_r == 17'd1) begin
              olast_nxt = 1'b1;
              rbusy_nxt = 1'b0;
            end
          end
        end
        default: ost_nxt = 1'b1;
      endcase
    end

    if (cmd.shr_drop) begin
      pos_nxt  = oldest_r;
      step_nxt = '0;
    end

    if (cmd.hdr_step) begin
      if (step_r < 3'd4) begin
        ram_re    = 1'b1;
        ram_raddr = pos_r;
        pos_nxt   = ring_inc(pos_r, ring_len);
      end
      if (step_r != 3'd0) begin
        hdr_nxt = {hdr_r[23:0], ram_rdata};
      end
      step_nxt = step_r + 3'd1;
    end

    if (cmd.hdr_next) begin
      if (sts.hdr_final) begin
        lkn_nxt = hdr_n;
        lkv_nxt = hdr_v;
      end else begin
        mod_start = 1'b1;
      end
    end

    if (cmd.mod_drop) begin
      oldest_nxt = mod_rem[AW-1:0];
      bused_nxt  = (18'(bused_r) >= drop_bytes) ? 13'(18'(bused_r) - drop_bytes) : '0;
      acc_nxt    = (18'(acc_r) >= drop_acc) ? 13'(18'(acc_r) - drop_acc) : '0;
      count_nxt  = count_r - 8'd1;
      if (count_r == 8'd1) begin
        oldest_nxt = '0;
        bused_nxt  = '0;
        acc_nxt    = '0;
      end
    end

    if (cmd.mod_walk) begin
      pos_nxt  = mod_rem[AW-1:0];
      skip_nxt = skip_r - 8'd1;
      step_nxt = '0;
    end

    if (cmd.ipos_start) begin
      mod_start = 1'b1;
      mod_dvd   = hpdt_pkg::DIV_W'(oldest_r) + hpdt_pkg::DIV_W'(bused_r);
    end

    if (cmd.ipos_set) begin
      pos_nxt  = mod_rem[AW-1:0];
      step_nxt = '0;
    end

    if (cmd.ihdr_step) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      unique case (step_r[1:0])
        2'd0: ram_wdata = nlen_r[15:8];
        2'd1: ram_wdata = nlen_r[7:0];
        2'd2: ram_wdata = vlen_r[15:8];
        2'd3: ram_wdata = vlen_r[7:0];
        default: ram_wdata = '0;
      endcase
      pos_nxt  = ring_inc(pos_r, ring_len);
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd3) begin
        if (len == 17'd0) begin
          bused_nxt = bused_r + 13'd4;
          acc_nxt   = acc_r + 13'(hpdt_pkg::ENTRY_OVERHEAD);
          count_nxt = count_r + 8'd1;
        end else begin
          wofs_nxt  = ring_inc(pos_r, ring_len);
          wleft_nxt = len;
          wtot_nxt  = len;
          wbusy_nxt = 1'b1;
        end
      end
    end

    if (cmd.lk_chk) begin
      if (lk_err) begin
        ost_nxt = 1'b1;
      end else begin
        onl_nxt   = lkn_r;
        ovl_nxt   = lkv_r;
        rrom_nxt  = lkrom_r;
        rleft_nxt = 17'(lkn_r) + (want_r ? 17'(lkv_r) : 17'd0);
        rcur_nxt  = lkrom_r ? '0 : pos_r;
        rbusy_nxt = (17'(lkn_r) + (want_r ? 17'(lkv_r) : 17'd0)) != 17'd0;
      end
    end

    if (cfg_we) begin
      unique case (cfg_index)
        hpdt_pkg::CFG_TABLE_LIMIT: begin
          limit_nxt  = cfg_data[12:0];
          max_nxt    = (cfg_data[12:0] > 13'(hpdt_pkg::RING_BYTES))
                       ? 13'(hpdt_pkg::RING_BYTES) : cfg_data[12:0];
          oldest_nxt = '0;
          bused_nxt  = '0;
          acc_nxt    = '0;
          count_nxt  = '0;
          wofs_nxt   = '0;
          rcur_nxt   = '0;
          wbusy_nxt  = 1'b0;
          rbusy_nxt  = 1'b0;
          rrom_nxt   = 1'b0;
        end
        hpdt_pkg::CFG_FIELD_CAP: cap_nxt = cfg_data;
        default: cap_nxt = cap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= 13'(hpdt_pkg::INITIAL_MAX);
      cap_r    <= 16'(hpdt_pkg::INITIAL_MAX);
      max_r    <= 13'(hpdt_pkg::INITIAL_MAX);
      oldest_r <= '0;  wofs_r <= '0;  rcur_r <= '0;  pos_r <= '0;
      bused_r  <= '0;  acc_r  <= '0;  target_r <= '0;
      count_r  <= '0;  skip_r <= '0;
      wleft_r  <= '0;  wtot_r <= '0;  rleft_r <= '0;
      wbusy_r  <= 1'b0; rbusy_r <= 1'b0; rrom_r <= 1'b0; fits_r <= 1'b0;
      slot_r   <= '0;  step_r <= '0;
      ost_r    <= 1'b0; olast_r <= 1'b0; ofram_r <= 1'b0;
    end else begin
      limit_r  <= limit_nxt;  cap_r <= cap_nxt;  max_r <= max_nxt;
      oldest_r <= oldest_nxt; wofs_r <= wofs_nxt; rcur_r <= rcur_nxt; pos_r <= pos_nxt;
      bused_r  <= bused_nxt;  acc_r <= acc_nxt;  target_r <= target_nxt;
      count_r  <= count_nxt;  skip_r <= skip_nxt;
      wleft_r  <= wleft_nxt;  wtot_r <= wtot_nxt; rleft_r <= rleft_nxt;
      wbusy_r  <= wbusy_nxt;  rbusy_r <= rbusy_nxt; rrom_r <= rrom_nxt; fits_r <= fits_nxt;
      slot_r   <= slot_nxt;   step_r <= step_nxt;
      ost_r    <= ost_nxt;    olast_r <= olast_nxt; ofram_r <= ofram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      nlen_r <= in_name_length;
      vlen_r <= in_value_length;
      idx_r  <= in_table_index;
      want_r <= in_want_value;
      db_r   <= in_data_byte;
      nmax_r <= in_new_max_size;
    end
    hdr_r   <= hdr_nxt;
    lkn_r   <= lkn_nxt;
    lkv_r   <= lkv_nxt;
    lkrom_r <= lkrom_nxt;
    onl_r   <= onl_nxt;
    ovl_r   <= ovl_nxt;
    ord_r   <= ord_nxt;
  end

  hpdt_ram #(
    .WIDTH(8),
    .DEPTH(hpdt_pkg::RING_BYTES)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hpdt_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(mod_dvd),
    .divisor (ring_len),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign out_status             = ost_r;
  assign out_entry_name_length  = onl_r;
  assign out_entry_value_length = ovl_r;
  assign out_read_data          = ofram_r ? ram_rdata : ord_r;
  assign out_last_octet         = olast_r;
  assign out_entries_held       = count_r;
  assign out_table_size         = acc_r;

  assert property (@(posedge clk) disable iff (!rst_n) cmd.idle |-> (acc_r <= max_r))
    else $error("Accounted size exceeds the maximum table size while idle.");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (count_r == 8'd0) |-> ((acc_r == 13'd0) && (bused_r == 13'd0)))
    else $error("Empty table still charges size or ring bytes.");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.idle |-> (bused_r <= acc_r))
    else $error("Ring bytes in use exceed the accounted size.");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the HPACK header table with a byte-ring dynamic part.
`timescale 1ns / 1ps

module tb;

  localparam int  CYCLE_LIMIT  = 30000000;
  localparam logic [2:0] REQ_TOP_CODE = 3'd7;

  typedef struct {
    logic [2:0]  req;
    logic [15:0] nlen;
    logic [15:0] vlen;
    logic [15:0] idx;
    logic        want;
    logic [7:0]  data;
    logic [15:0] nmax;
  } request_t;

  typedef struct {
    logic        status;
    logic [15:0] nlen;
    logic [15:0] vlen;
    logic [7:0]  rdata;
    logic        last;
    logic [7:0]  held;
    logic [12:0] size;
  } reply_t;

  class header_table_scoreboard;
    string hdr_name[61] = '{
      ":authority", ":method", ":method", ":path", ":path", ":scheme", ":scheme",
      ":status", ":status", ":status", ":status", ":status", ":status", ":status",
      "accept-charset", "accept-encoding", "accept-language", "accept-ranges", "accept",
      "access-control-allow-origin", "age", "allow", "authorization", "cache-control",
      "content-disposition", "content-encoding", "content-language", "content-length",
      "content-location", "content-range", "content-type", "cookie", "date", "etag",
      "expect", "expires", "from", "host", "if-match", "if-modified-since",
      "if-none-match", "if-range", "if-unmodified-since", "last-modified", "link",
      "location", "max-forwards", "proxy-authenticate", "proxy-authorization", "range",
      "referer", "refresh", "retry-after", "server", "set-cookie",
      "strict-transport-security", "transfer-encoding", "user-agent", "vary", "via",
      "www-authenticate"};
    string hdr_value[61] = '{
      "", "GET", "POST", "/", "/index.html", "http", "https", "200", "204", "206", "304",
      "400", "404", "500", "", "gzip, deflate", "", "", "", "", "", "", "", "", "", "", "",
      "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "",
      "", "", "", "", "", "", "", "", "", "", "", "", ""};

    logic [7:0]  ring[hpdt_pkg::RING_BYTES];
    int unsigned oldest, used, charged, max_size, count;
    int unsigned wr_pos, wr_left, wr_total, rd_pos, rd_left, rd_nlen, rd_slot;
    int unsigned limit, capacity;
    bit          wr_busy, rd_busy, rd_static;
    reply_t      awaited[$];
    int          errors;

    function new();
      limit    = 4096;
      capacity = 4096;
      errors   = 0;
      clear_table();
    endfunction

    function int unsigned ring_len();
      return (limit > hpdt_pkg::RING_BYTES) ? hpdt_pkg::RING_BYTES : limit;
    endfunction

    function int unsigned adv(int unsigned pos, int unsigned n);
      if (ring_len() == 0) return 0;
      return (pos + n) % ring_len();
    endfunction

    function void read_header(inout int unsigned pos, output int unsigned n,
                              output int unsigned v);
      logic [7:0] h[4];
      for (int i = 0; i < 4; i++) begin
        h[i] = ring[pos];
        pos  = adv(pos, 1);
      end
      n = {h[0], h[1]};
      v = {h[2], h[3]};
    endfunction

    function void drop_entry();
      int unsigned pos, n, v, acc;
      pos = oldest;
      read_header(pos, n, v);
      acc     = n + v + hpdt_pkg::ENTRY_OVERHEAD;
      oldest  = adv(oldest, n + v + 4);
      used    = (used >= n + v + 4) ? used - (n + v + 4) : 0;
      charged = (charged >= acc) ? charged - acc : 0;
      count--;
      if (count == 0) begin
        oldest  = 0;
        used    = 0;
        charged = 0;
      end
    endfunction

    function void shrink_table(int unsigned room);
      while (count != 0 && charged > room) drop_entry();
    endfunction

    function void commit(int unsigned len);
      used    += len + 4;
      charged += len + hpdt_pkg::ENTRY_OVERHEAD;
      count++;
      wr_busy = 0;
    endfunction

    function void clear_table();
      oldest   = 0;
      used     = 0;
      charged  = 0;
      count    = 0;
      max_size = (ring_len() < hpdt_pkg::INITIAL_MAX) ? ring_len() : hpdt_pkg::INITIAL_MAX;
      wr_pos   = 0;
      rd_pos   = 0;
      wr_busy  = 0;
      rd_busy  = 0;
      rd_static = 0;
      wr_left  = 0;
      wr_total = 0;
      rd_left  = 0;
      rd_nlen  = 0;
      rd_slot  = 0;
    endfunction

    function void write_register(logic index, int unsigned value);
      if (index == hpdt_pkg::CFG_TABLE_LIMIT) begin
        limit = value & 16'h1FFF;
        clear_table();
      end else begin
        capacity = value & 16'hFFFF;
      end
    endfunction

    function void note_request(request_t r);
      reply_t      e;
      int unsigned len, pos, n, v, d;
      bit          ok, from_rom;
      e = '{default: '0};
      case (r.req)
        hpdt_pkg::REQ_SIZE: begin
          wr_busy = 0;
          rd_busy = 0;
          if (r.nmax > ring_len()) begin
            e.status = 1;
          end else begin
            max_size = r.nmax;
            shrink_table(max_size);
          end
        end
        hpdt_pkg::REQ_INS_BEGIN: begin
          len = r.nlen + r.vlen;
          wr_busy = 0;
          rd_busy = 0;
          if (len > max_size || max_size - len < hpdt_pkg::ENTRY_OVERHEAD) begin
            shrink_table(0);
          end else begin
            shrink_table(max_size - (len + hpdt_pkg::ENTRY_OVERHEAD));
            pos = adv(oldest, used);
            ring[pos] = r.nlen[15:8]; pos = adv(pos, 1);
            ring[pos] = r.nlen[7:0];  pos = adv(pos, 1);
            ring[pos] = r.vlen[15:8]; pos = adv(pos, 1);
            ring[pos] = r.vlen[7:0];  pos = adv(pos, 1);
            if (len == 0) begin
              commit(0);
            end else begin
              wr_pos   = pos;
              wr_left  = len;
              wr_total = len;
              wr_busy  = 1;
            end
          end
        end
        hpdt_pkg::REQ_INS_BYTE: begin
          if (!wr_busy) begin
            e.status = 1;
          end else begin
            ring[wr_pos] = r.data;
            wr_pos = adv(wr_pos, 1);
            wr_left--;
            if (wr_left == 0) commit(wr_total);
          end
        end
        hpdt_pkg::REQ_LOOKUP: begin
          n = 0;
          v = 0;
          pos = 0;
          ok = 1;
          from_rom = 0;
          rd_busy = 0;
          if (r.idx == 0) begin
            ok = 0;
          end else if (r.idx <= hpdt_pkg::STATIC_ENTRIES) begin
            from_rom = 1;
            rd_slot = r.idx - 1;
            n = hdr_name[rd_slot].len();
            v = hdr_value[rd_slot].len();
          end else begin
            d = r.idx - (hpdt_pkg::STATIC_ENTRIES + 1);
            if (d >= count) begin
              ok = 0;
            end else begin
              pos = oldest;
              for (int unsigned k = 0; k < count - 1 - d; k++) begin
                read_header(pos, n, v);
                pos = adv(pos, n + v);
              end
              read_header(pos, n, v);
            end
          end
          if (ok && (n > capacity || (r.want && v > capacity - n))) ok = 0;
          if (!ok) begin
            e.status = 1;
          end else begin
            e.nlen    = n;
            e.vlen    = v;
            rd_static = from_rom;
            rd_nlen   = n;
            rd_left   = n + (r.want ? v : 0);
            rd_pos    = from_rom ? 0 : pos;
            rd_busy   = rd_left != 0;
          end
        end
        hpdt_pkg::REQ_READ: begin
          if (!rd_busy) begin
            e.status = 1;
          end else begin
            if (rd_static) begin
              e.rdata = (rd_pos < rd_nlen) ? hdr_name[rd_slot][rd_pos]
                                           : hdr_value[rd_slot][rd_pos - rd_nlen];
              rd_pos++;
            end else begin
              e.rdata = ring[rd_pos];
              rd_pos = adv(rd_pos, 1);
            end
            rd_left--;
            if (rd_left == 0) begin
              e.last  = 1;
              rd_busy = 0;
            end
          end
        end
        default: e.status = 1;
      endcase
      e.held = count;
      e.size = charged;
      awaited.push_back(e);
    endfunction

    function void check_reply(reply_t a);
      reply_t e;
      if (awaited.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status); errors++;
      end
      if (a.nlen !== e.nlen) begin
        $error("entry_name_length: expected %0d, got %0d", e.nlen, a.nlen); errors++;
      end
      if (a.vlen !== e.vlen) begin
        $error("entry_value_length: expected %0d, got %0d", e.vlen, a.vlen); errors++;
      end
      if (a.rdata !== e.rdata) begin
        $error("read_data: expected %0h, got %0h", e.rdata, a.rdata); errors++;
      end
      if (a.last !== e.last) begin
        $error("last_octet: expected %0d, got %0d", e.last, a.last); errors++;
      end
      if (a.held !== e.held) begin
        $error("entries_held: expected %0d, got %0d", e.held, a.held); errors++;
      end
      if (a.size !== e.size) begin
        $error("table_size: expected %0d, got %0d", e.size, a.size); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy, done;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = '0;
  logic [2:0]  in_req_type = '0;
  logic [15:0] in_name_length = '0, in_value_length = '0, in_table_index = '0;
  logic        in_want_value = 0;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_new_max_size = '0;
  logic        out_status, out_last_octet;
  logic [15:0] out_entry_name_length, out_entry_value_length;
  logic [7:0]  out_read_data, out_entries_held;
  logic [12:0] out_table_size;

  header_table_scoreboard table_sb = new();
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned phase_items;

  hpack_dynamic_table_ring i_dut (
    .clk, .rst_n, .start, .busy, .done, .cfg_we, .cfg_index, .cfg_data,
    .in_req_type, .in_name_length, .in_value_length, .in_table_index, .in_want_value,
    .in_data_byte, .in_new_max_size, .out_status, .out_entry_name_length,
    .out_entry_value_length, .out_read_data, .out_last_octet, .out_entries_held,
    .out_table_size
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && done) begin
      table_sb.check_reply('{out_status, out_entry_name_length, out_entry_value_length,
                             out_read_data, out_last_octet, out_entries_held,
                             out_table_size});
    end
  end

  function automatic request_t random_request(logic [2:0] req);
    request_t r;
    r.req  = req;
    r.nlen = 16'($urandom);
    r.vlen = 16'($urandom);
    r.idx  = 16'($urandom);
    r.want = 1'($urandom);
    r.data = 8'($urandom);
    r.nmax = 16'($urandom);
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with start low.
  task automatic send(request_t r);
    in_req_type     = r.req;
    in_name_length  = r.nlen;
    in_value_length = r.vlen;
    in_table_index  = r.idx;
    in_want_value   = r.want;
    in_data_byte    = r.data;
    in_new_max_size = r.nmax;
    start = 1;
    do @(posedge clk); while (busy);
    table_sb.note_request(r);
    phase_items++;
    @(negedge clk);
    start = 0;
    if ($urandom_range(99) < sender_idle_pct) repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    while (table_sb.awaited.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_cfg(logic index, int unsigned value);
    drain();
    cfg_we    = 1;
    cfg_index = index;
    cfg_data  = 16'(value);
    table_sb.write_register(index, value);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic insert_entry(int unsigned nl, int unsigned vl, bit cut_short);
    request_t r;
    r = random_request(hpdt_pkg::REQ_INS_BEGIN);
    r.nlen = 16'(nl);
    r.vlen = 16'(vl);
    send(r);
    for (int unsigned k = 0; k < nl + vl; k++) begin
      if (cut_short && $urandom_range(9) == 0) break;
      send(random_request(hpdt_pkg::REQ_INS_BYTE));
    end
  endtask

  task automatic lookup_and_stream(int unsigned index, bit want, bit overrun);
    request_t r;
    r = random_request(hpdt_pkg::REQ_LOOKUP);
    r.idx  = 16'(index);
    r.want = want;
    send(r);
    while (table_sb.rd_busy) send(random_request(hpdt_pkg::REQ_READ));
    if (overrun) send(random_request(hpdt_pkg::REQ_READ));
  endtask

  task automatic random_phase(int unsigned target);
    request_t r;
    int unsigned pick;
    phase_items = 0;
    while (phase_items < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        if ($urandom_range(9) == 0)
          insert_entry($urandom_range(0, 150), $urandom_range(0, 150), 1);
        else
          insert_entry($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(19) == 0);
      end else if (pick < 65) begin
        pick = $urandom_range(9);
        if (pick < 6)
          lookup_and_stream(hpdt_pkg::STATIC_ENTRIES + 1 + $urandom_range(0, table_sb.count),
                            1'($urandom), $urandom_range(4) == 0);
        else if (pick < 9)
          lookup_and_stream($urandom_range(0, hpdt_pkg::STATIC_ENTRIES), 1'($urandom),
                            $urandom_range(4) == 0);
        else
          lookup_and_stream($urandom_range(0, 16'hFFFF), 1'($urandom), 0);
      end else if (pick < 75) begin
        r = random_request(hpdt_pkg::REQ_SIZE);
        if ($urandom_range(3) != 0) r.nmax = 16'($urandom_range(0, table_sb.ring_len()));
        send(r);
      end else begin
        send(random_request(3'($urandom_range(0, REQ_TOP_CODE))));
      end
    end
  endtask

  request_t dr;

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed beats: extremes, every request and the corner cases.
    dr = random_request(hpdt_pkg::REQ_SIZE); dr.nmax = 16'hFFFF; send(dr);
    dr = random_request(hpdt_pkg::REQ_SIZE); dr.nmax = 16'd4096; send(dr);
    insert_entry(0, 0, 0);
    insert_entry(2, 1, 0);
    send(random_request(hpdt_pkg::REQ_INS_BYTE));
    lookup_and_stream(0, 1, 1);
    lookup_and_stream(2, 1, 1);
    lookup_and_stream(hpdt_pkg::STATIC_ENTRIES, 0, 0);
    lookup_and_stream(hpdt_pkg::STATIC_ENTRIES + 1, 1, 1);
    lookup_and_stream(hpdt_pkg::STATIC_ENTRIES + 2, 0, 0);
    lookup_and_stream(16'hFFFF, 1, 0);
    dr = random_request(hpdt_pkg::REQ_INS_BEGIN); dr.nlen = 16'd3; dr.vlen = 16'd0; send(dr);
    dr = random_request(hpdt_pkg::REQ_SIZE); dr.nmax = 16'd0; send(dr);
    dr = random_request(hpdt_pkg::REQ_INS_BEGIN);
    dr.nlen = 16'hFFFF; dr.vlen = 16'hFFFF; send(dr);
    for (int c = hpdt_pkg::REQ_READ + 1; c <= REQ_TOP_CODE; c++) send(random_request(3'(c)));
    dr = random_request(hpdt_pkg::REQ_INS_BEGIN);
    dr.nlen = 16'd0; dr.vlen = 16'd4064; send(dr);

    write_cfg(hpdt_pkg::CFG_FIELD_CAP, 4);
    lookup_and_stream(5, 1, 0);
    lookup_and_stream(4, 1, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_cfg(hpdt_pkg::CFG_TABLE_LIMIT, 4096); write_cfg(hpdt_pkg::CFG_FIELD_CAP, 65535);
        end
        1: begin
          write_cfg(hpdt_pkg::CFG_TABLE_LIMIT, 300);  write_cfg(hpdt_pkg::CFG_FIELD_CAP, 10);
        end
        2: begin
          write_cfg(hpdt_pkg::CFG_TABLE_LIMIT, 0);    write_cfg(hpdt_pkg::CFG_FIELD_CAP, 0);
        end
        3: begin
          write_cfg(hpdt_pkg::CFG_TABLE_LIMIT, 1000); write_cfg(hpdt_pkg::CFG_FIELD_CAP, 4096);
        end
        4: begin
          write_cfg(hpdt_pkg::CFG_TABLE_LIMIT, 8191); write_cfg(hpdt_pkg::CFG_FIELD_CAP, 20);
        end
        default: begin
          write_cfg(hpdt_pkg::CFG_TABLE_LIMIT, 97);   write_cfg(hpdt_pkg::CFG_FIELD_CAP, 65535);
        end
      endcase
      case (ph % 4)
        1:       sender_idle_pct = 87;
        3:       sender_idle_pct = 33;
        default: sender_idle_pct = 0;
      endcase
      random_phase(320);
    end

    drain();
    repeat (50) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
